@@ src/utf8v_pkg.sv @@
// Package: shared types and constants for the UTF-8 stream validator.
`default_nettype none

package utf8v_pkg;

    // Status codes carried in the result and in the latched state
    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_NULL    = 2'd2
    } t_status;

    localparam int unsigned CONT_W = 3;

    // Lead byte masks and their match patterns
    localparam logic [7:0] MASK_1 = 8'h80;
    localparam logic [7:0] MASK_2 = 8'hE0;
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] MASK_3 = 8'hF0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] MASK_4 = 8'hF8;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] MASK_5 = 8'hFC;
    localparam logic [7:0] LEAD_5 = 8'hF8;
    localparam logic [7:0] MASK_6 = 8'hFE;
    localparam logic [7:0] LEAD_6 = 8'hFC;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] CONT_PAT  = 8'h80;

    localparam logic [CONT_W-1:0] CONT_MAX = 3'd5;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_ZERO_OK = 2'd0;

    // Next state and result of one byte step
    typedef struct packed {
        logic [CONT_W-1:0] cont_due;
        t_status           status;
        t_status           result;
    } t_step;

endpackage

`default_nettype wire

@@ src/utf8v_decode.sv @@
// Byte decoder: lead/continuation check and next-state logic for one byte.
`default_nettype none

module utf8v_decode
    import utf8v_pkg::*;
(
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_last,
    input  wire logic              i_zero_ok,
    input  wire logic [CONT_W-1:0] i_cont_due,
    input  var  t_status           i_status,
    output t_step                  o_step
);

    logic              is_lead;
    logic [CONT_W-1:0] lead_cont;
    logic [CONT_W-1:0] cont_upd;
    t_status           stat_upd;

    // Continuations that follow a lead byte; is_lead low for a bad lead
    always_comb begin
        is_lead   = 1'b1;
        lead_cont = 3'd0;
        if ((i_byte & MASK_1) == 8'h00) begin
            lead_cont = 3'd0;
        end else if ((i_byte & MASK_2) == LEAD_2) begin
            lead_cont = 3'd1;
        end else if ((i_byte & MASK_3) == LEAD_3) begin
            lead_cont = 3'd2;
        end else if ((i_byte & MASK_4) == LEAD_4) begin
            lead_cont = 3'd3;
        end else if ((i_byte & MASK_5) == LEAD_5) begin
            lead_cont = 3'd4;
        end else if ((i_byte & MASK_6) == LEAD_6) begin
            lead_cont = 3'd5;
        end else begin
            is_lead = 1'b0;
        end
    end

    always_comb begin
        cont_upd = i_cont_due;
        stat_upd = i_status;
        if (i_status == ST_VALID) begin
            if (i_cont_due != 3'd0) begin
                if ((i_byte & MASK_CONT) != CONT_PAT) begin
                    stat_upd = ST_INVALID;
                end else begin
                    cont_upd = i_cont_due - 3'd1;
                end
            end else if (!is_lead) begin
                stat_upd = ST_INVALID;
            end else if (i_byte == 8'h00 && !i_zero_ok) begin
                stat_upd = ST_NULL;
            end else begin
                cont_upd = lead_cont;
            end
        end

        // Flag a truncated sequence at the end of the message
        o_step.result = stat_upd;
        if (stat_upd == ST_VALID && cont_upd != 3'd0) begin
            o_step.result = ST_INVALID;
        end

        // Clear for the next message after the last byte
        if (i_last) begin
            o_step.cont_due = 3'd0;
            o_step.status   = ST_VALID;
        end else begin
            o_step.cont_due = cont_upd;
            o_step.status   = stat_upd;
        end
    end

endmodule

`default_nettype wire

@@ src/utf8v_out_reg.sv @@
// Result register: holds one status transfer until the consumer takes it.
`default_nettype none

module utf8v_out_reg
    import utf8v_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  var  t_status i_status,
    output logic      o_free,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_status   o_status
);

    logic    r_valid;
    t_status r_status;

    // Free when empty or when the held transfer leaves this cycle
    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_status <= i_status;
        end
    end

endmodule

`default_nettype wire

@@ src/utf8_stream_validator_top.sv @@
// Top level: UTF-8 stream validator with input register, state and APB register.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------------
//   in       | sink      | i_in_valid / o_in_stall   | i_data_byte[7:0], i_last
//   out      | source    | o_out_valid / i_out_stall | o_status[1:0]
//   cfg      | APB slave | psel, penable, pready     | paddr[1:0], pwdata, prdata
//
// One byte is taken every cycle unless the input stalls; a byte passes the input
// register, is decoded against the continuation count and latched status, and
// the last byte of a message loads the status into the result register as it advances.
// Reset (synchronous, active low) empties both registers and clears the count,
// the latched status and the null-acceptance bit.
// A stalled result holds; the input stalls only when a last byte waits on a
// full result register, and bytes that are not last keep flowing meanwhile.
`default_nettype none

module utf8_stream_validator_top
    import utf8v_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // Message state
    logic [CONT_W-1:0] r_cont_due;
    t_status           r_status;
    logic              r_zero_ok;

    t_step   step;
    logic    out_free;
    logic    advance;
    t_status out_status;
    logic    cfg_wr;

    // Advance the held byte unless it is last and the result register is full
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Capture payload only on a transfer
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    utf8v_decode u_decode (
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_zero_ok    (r_zero_ok),
        .i_cont_due   (r_cont_due),
        .i_status     (r_status),
        .o_step       (step)
    );

    // Update the count and latched status once per advanced byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cont_due <= '0;
            r_status   <= ST_VALID;
        end else if (advance) begin
            r_cont_due <= step.cont_due;
            r_status   <= step.status;
        end
    end

    utf8v_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && r_in_last),
        .i_status (step.result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_status (out_status)
    );

    assign o_status = out_status;

    // APB: write on the access phase; pready is tied high
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_ok <= 1'b0;
        end else if (cfg_wr && paddr == REG_ZERO_OK) begin
            r_zero_ok <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == REG_ZERO_OK) begin
            prdata[0] = r_zero_ok;
        end
    end

    // The last byte of a message leaves clean state behind
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_cont_due == 3'd0 && r_status == ST_VALID))
        else $error("state not cleared after last byte");

    // A new result appears only after a last byte was decoded
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(advance && r_in_last))
        else $error("result without a last byte");

    // The continuation count never exceeds a six-byte sequence
    a_cont_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cont_due <= CONT_MAX)
        else $error("continuation count out of range");

    // A latched error holds until a byte advances
    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_VALID && !advance) |=> $stable(r_status))
        else $error("latched status changed without a byte");

endmodule

`default_nettype wire
